/* rtl/clb_pkg.sv */
// shared types and constants of the look-at camera basis block
`timescale 1ns / 1ps
package clb_pkg;
	localparam int FRAC_BITS = 14;
	localparam int ONE = 1 << FRAC_BITS;
	localparam int QW = 16;
	localparam int WW = 100;
	localparam int NLANE = 5;
	localparam int NCELL = 16;
	localparam int TGT_SHIFT = 2 * FRAC_BITS + 2;

	// saturated plus and minus one in the output format
	localparam logic signed [15:0] ONE_Q = (ONE > 32767) ? 16'sh7fff : 16'(ONE);
	localparam logic signed [15:0] NEG_ONE_Q = (ONE > 32768) ? 16'sh8000 : 16'(-ONE);

	// lane order within a cell
	localparam int L_RX = 0;
	localparam int L_RZ = 1;
	localparam int L_UX = 2;
	localparam int L_UY = 3;
	localparam int L_UZ = 4;

	typedef struct packed {
		logic [WW-1:0] den;
		logic [WW-1:0] tgt;
		logic signed [WW-1:0] p;
		logic signed [WW-1:0] r;
		logic [QW-1:0] q;
		logic neg;
	} lane_t;

	typedef struct packed {
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		logic signed [15:0] fz;
		logic up;
		logic dn;
		logic degen;
	} side_t;

	typedef struct packed {
		lane_t [NLANE-1:0] lane;
		side_t side;
	} cell_data_t;
endpackage

/* rtl/clb_orient_if.sv */
// orientation channel
`timescale 1ns / 1ps
interface clb_orient_if;
	logic valid;
	logic ready;
	logic signed [15:0] orient_x;
	logic signed [15:0] orient_y;
	logic signed [15:0] orient_z;
	modport source(output valid, orient_x, orient_y, orient_z, input ready);
	modport sink(input valid, orient_x, orient_y, orient_z, output ready);
endinterface

/* rtl/clb_basis_if.sv */
// camera basis result channel
`timescale 1ns / 1ps
interface clb_basis_if;
	logic valid;
	logic ready;
	logic signed [15:0] right_x;
	logic signed [15:0] right_y;
	logic signed [15:0] right_z;
	logic signed [15:0] up_x;
	logic signed [15:0] up_y;
	logic signed [15:0] up_z;
	logic signed [15:0] fwd_x;
	logic signed [15:0] fwd_y;
	logic signed [15:0] fwd_z;
	logic degenerate;
	modport source(output valid, right_x, right_y, right_z, up_x, up_y, up_z,
		fwd_x, fwd_y, fwd_z, degenerate, input ready);
	modport sink(input valid, right_x, right_y, right_z, up_x, up_y, up_z,
		fwd_x, fwd_y, fwd_z, degenerate, output ready);
endinterface

/* rtl/clb_front.sv */
// front pipeline: forward vector, products, squared numerators and denominators
`timescale 1ns / 1ps
module clb_front (
	input logic clk,
	input logic arst_n,
	clb_orient_if.sink orient,
	output logic out_valid,
	output clb_pkg::cell_data_t out_data,
	input logic out_ready
);
	import clb_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	logic signed [15:0] fx, fy, fz;
	logic xz0, up_c, dn_c;

	side_t side_s1, side_s2;
	logic [31:0] fx2_s1, fy2_s1, fz2_s1;
	logic signed [31:0] fxy_s1, fyz_s1;

	logic [31:0] s2_s2, sum_s2, fx2_s2, fz2_s2;
	logic [30:0] mxy_s2, myz_s2;
	logic [NLANE-1:0] neg_s2;

	cell_data_t d_s3;

	assign rdy3 = !v_s3 || out_ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign orient.ready = rdy1;
	assign out_valid = v_s3;
	assign out_data = d_s3;

	// forward is the saturated negation of the orientation
	always_comb begin
		fx = (orient.orient_x == 16'sh8000) ? 16'sh7fff : -orient.orient_x;
		fy = (orient.orient_y == 16'sh8000) ? 16'sh7fff : -orient.orient_y;
		fz = (orient.orient_z == 16'sh8000) ? 16'sh7fff : -orient.orient_z;
		xz0 = (orient.orient_x == 16'sd0) && (orient.orient_z == 16'sd0);
		up_c = xz0 && (32'(orient.orient_y) == ONE);
		dn_c = xz0 && (32'(orient.orient_y) == -ONE);
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= orient.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// stage 1: small products
	always_ff @(posedge clk) begin
		if (rdy1) begin
			side_s1.fx <= fx;
			side_s1.fy <= fy;
			side_s1.fz <= fz;
			side_s1.up <= up_c;
			side_s1.dn <= dn_c;
			side_s1.degen <= xz0 && !up_c && !dn_c;
			fx2_s1 <= 32'(fx) * 32'(fx);
			fy2_s1 <= 32'(fy) * 32'(fy);
			fz2_s1 <= 32'(fz) * 32'(fz);
			fxy_s1 <= fx * fy;
			fyz_s1 <= fy * fz;
		end
	end

	// stage 2: sums, magnitudes and result signs
	always_ff @(posedge clk) begin
		if (rdy2) begin
			side_s2 <= side_s1;
			s2_s2 <= fx2_s1 + fz2_s1;
			sum_s2 <= fx2_s1 + fz2_s1 + fy2_s1;
			fx2_s2 <= fx2_s1;
			fz2_s2 <= fz2_s1;
			mxy_s2 <= fxy_s1[31] ? 31'(-fxy_s1) : fxy_s1[30:0];
			myz_s2 <= fyz_s1[31] ? 31'(-fyz_s1) : fyz_s1[30:0];
			neg_s2[L_RX] <= side_s1.fz[15];
			neg_s2[L_RZ] <= (side_s1.fx > 16'sd0);
			neg_s2[L_UX] <= (fxy_s1 > 32'sd0);
			neg_s2[L_UY] <= 1'b0;
			neg_s2[L_UZ] <= (fyz_s1 > 32'sd0);
		end
	end

	// stage 3: wide products and lane start values
	logic [63:0] dup, t_ux, t_uy, t_uz;
	logic [WW-1:0] den_c [NLANE];
	logic [63:0] m2_c [NLANE];

	always_comb begin
		dup = 64'(s2_s2) * 64'(sum_s2);
		t_ux = 64'(mxy_s2) * 64'(mxy_s2);
		t_uy = 64'(s2_s2) * 64'(s2_s2);
		t_uz = 64'(myz_s2) * 64'(myz_s2);
		den_c[L_RX] = WW'(s2_s2);
		den_c[L_RZ] = WW'(s2_s2);
		den_c[L_UX] = WW'(dup);
		den_c[L_UY] = WW'(dup);
		den_c[L_UZ] = WW'(dup);
		m2_c[L_RX] = 64'(fz2_s2);
		m2_c[L_RZ] = 64'(fx2_s2);
		m2_c[L_UX] = t_ux;
		m2_c[L_UY] = t_uy;
		m2_c[L_UZ] = t_uz;
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			d_s3.side <= side_s2;
			for (int i = 0; i < NLANE; i++) begin
				d_s3.lane[i].den <= den_c[i];
				d_s3.lane[i].tgt <= WW'(m2_c[i]) << TGT_SHIFT;
				d_s3.lane[i].p <= $signed(den_c[i]);
				d_s3.lane[i].r <= -$signed(den_c[i]);
				d_s3.lane[i].q <= '0;
				d_s3.lane[i].neg <= neg_s2[i];
			end
		end
	end
endmodule

/* rtl/clb_cell.sv */
// one cell of the root-divide chain: settles one quotient bit in every lane
`timescale 1ns / 1ps
module clb_cell (
	input logic clk,
	input logic arst_n,
	input logic [3:0] bit_idx,
	input logic in_valid,
	input clb_pkg::cell_data_t in_data,
	output logic in_ready,
	output logic out_valid,
	output clb_pkg::cell_data_t out_data,
	input logic out_ready
);
	import clb_pkg::*;

	logic v_q;
	cell_data_t d_q;
	cell_data_t nxt;
	logic [6:0] sh_r, sh_d, sh_i;

	assign in_ready = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_data = d_q;

	// trial q | bit: keep it when den * (2q - 1)^2 stays within the target
	always_comb begin
		logic signed [WW-1:0] den_s, p_c;
		logic [QW-1:0] q_c;
		sh_r = 7'(bit_idx) + 7'd2;
		sh_d = {2'b0, bit_idx, 1'b0} + 7'd2;
		sh_i = 7'(bit_idx) + 7'd1;
		nxt = in_data;
		for (int i = 0; i < NLANE; i++) begin
			den_s = $signed(in_data.lane[i].den);
			q_c = in_data.lane[i].q | (QW'(1) << bit_idx);
			p_c = in_data.lane[i].p + (in_data.lane[i].r <<< sh_r) + (den_s <<< sh_d);
			if (!in_data.lane[i].q[QW-1] && (p_c <= $signed(in_data.lane[i].tgt))) begin
				nxt.lane[i].p = p_c;
				nxt.lane[i].r = in_data.lane[i].r + (den_s <<< sh_i);
				nxt.lane[i].q = q_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (in_ready) v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready) d_q <= nxt;
	end
endmodule

/* rtl/camera_look_at_basis.sv */
// top level: look-at camera basis from an orientation vector
`timescale 1ns / 1ps
// Takes one orientation vector (Q2.14) per transaction on the orient channel and
// returns right, up and forward basis vectors (Q2.14) plus a degenerate flag on
// the basis channel, one result transaction per orientation, in order.
// The path from the accepting edge to basis.valid runs through 20 register
// stages: three front stages (negation and small products, sums, wide products),
// a chain of 16 cells that each settle one bit of the five rounded root
// quotients, and an output register.
// Throughput is one transaction per cycle while the receiver keeps up; every
// stage and cell has its own valid bit, so bubbles close up and a new
// orientation is taken while results wait. When the receiver stalls, the chain
// fills up and orient.ready drops only once every stage holds a transaction.
// Reset clears all valid bits; no stored data needs clearing.
// Straight up and straight down orientations give fixed bases; other inputs
// with zero x and z raise degenerate with all vector fields zero.
module camera_look_at_basis (
	input logic clk,
	input logic arst_n,
	clb_orient_if.sink orient,
	clb_basis_if.source basis
);
	import clb_pkg::*;

	logic cv [NCELL+1];
	logic cr [NCELL+1];
	cell_data_t cd [NCELL+1];

	clb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.orient(orient),
		.out_valid(cv[0]),
		.out_data(cd[0]),
		.out_ready(cr[0])
	);

	// chain of bit cells, most significant quotient bit first
	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		clb_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.bit_idx(4'(NCELL - 1 - g)),
			.in_valid(cv[g]),
			.in_data(cd[g]),
			.in_ready(cr[g]),
			.out_valid(cv[g+1]),
			.out_data(cd[g+1]),
			.out_ready(cr[g+1])
		);
	end

	// final signs, saturation and special cases
	logic signed [15:0] res [NLANE];
	side_t sd;
	logic v_q;

	assign sd = cd[NCELL].side;
	assign cr[NCELL] = !v_q || basis.ready;

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			if (cd[NCELL].lane[i].neg) res[i] = -$signed(cd[NCELL].lane[i].q);
			else if (cd[NCELL].lane[i].q[QW-1]) res[i] = 16'sh7fff;
			else res[i] = $signed(cd[NCELL].lane[i].q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (cr[NCELL]) v_q <= cv[NCELL];
	end

	// output register
	logic signed [15:0] rx_q, ry_q, rz_q, ux_q, uy_q, uz_q, fx_q, fy_q, fz_q;
	logic dg_q;

	always_ff @(posedge clk) begin
		if (cr[NCELL]) begin
			if (sd.up || sd.dn) begin
				rx_q <= ONE_Q;
				ry_q <= '0;
				rz_q <= '0;
				ux_q <= '0;
				uy_q <= '0;
				uz_q <= sd.up ? ONE_Q : NEG_ONE_Q;
				fx_q <= '0;
				fy_q <= sd.up ? NEG_ONE_Q : ONE_Q;
				fz_q <= '0;
				dg_q <= 1'b0;
			end else if (sd.degen) begin
				rx_q <= '0;
				ry_q <= '0;
				rz_q <= '0;
				ux_q <= '0;
				uy_q <= '0;
				uz_q <= '0;
				fx_q <= '0;
				fy_q <= '0;
				fz_q <= '0;
				dg_q <= 1'b1;
			end else begin
				rx_q <= res[L_RX];
				ry_q <= '0;
				rz_q <= res[L_RZ];
				ux_q <= res[L_UX];
				uy_q <= res[L_UY];
				uz_q <= res[L_UZ];
				fx_q <= sd.fx;
				fy_q <= sd.fy;
				fz_q <= sd.fz;
				dg_q <= 1'b0;
			end
		end
	end

	assign basis.valid = v_q;
	assign basis.right_x = rx_q;
	assign basis.right_y = ry_q;
	assign basis.right_z = rz_q;
	assign basis.up_x = ux_q;
	assign basis.up_y = uy_q;
	assign basis.up_z = uz_q;
	assign basis.fwd_x = fx_q;
	assign basis.fwd_y = fy_q;
	assign basis.fwd_z = fz_q;
	assign basis.degenerate = dg_q;

`ifndef NO_ASSERTIONS
	// a degenerate result carries zero right_x, up_y and fwd_y
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		basis.valid && basis.degenerate |-> basis.right_x == 16'sd0 &&
		basis.up_y == 16'sd0 && basis.fwd_y == 16'sd0)
		else $error("degenerate result with nonzero basis");
	// the up vector never points below the horizon
	a_up_y_sign: assert property (@(posedge clk) disable iff (!arst_n)
		basis.valid |-> !basis.up_y[15])
		else $error("negative up_y");
	// up_y quotients never pass the search bound of 32768
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cv[NCELL] |-> !(cd[NCELL].lane[L_UY].q[QW-1] && (|cd[NCELL].lane[L_UY].q[QW-2:0])))
		else $error("quotient beyond bound");
`endif
endmodule

/* bench/clb_bench_if.sv */
// bench package: expected basis record used by the checker
`timescale 1ns / 1ps
package clb_bench_pkg;
	// expected basis for one orientation
	typedef struct packed {
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic signed [15:0] rz;
		logic signed [15:0] ux;
		logic signed [15:0] uy;
		logic signed [15:0] uz;
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		logic signed [15:0] fz;
		logic degen;
	} basis_t;
endpackage

/* bench/clb_checker.sv */
// checker: predicts the camera basis for each orientation and compares results
`timescale 1ns / 1ps
module clb_checker (
	input logic clk,
	input logic arst_n,
	clb_orient_if orient,
	clb_basis_if basis,
	output int fail_count,
	output int pending
);
	import clb_pkg::*;
	import clb_bench_pkg::*;

	basis_t basis_queue[$];
	int fails = 0;

	function automatic logic signed [15:0] sat_q(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return -16'sh8000;
		return 16'(v);
	endfunction

	// num / sqrt(den), nearest with ties away from zero, by bisection on (2q-1)^2*den <= 4num^2
	function automatic logic signed [15:0] root_quot(longint num, longint unsigned den);
		logic [255:0] target, trial;
		logic [127:0] mag;
		longint lo, hi, q;
		lo = 0;
		hi = 32768;
		mag = (num < 0) ? 128'(-num) : 128'(num);
		target = 256'(mag) * 256'(mag) * 4;
		while (lo < hi) begin
			q = (lo + hi + 1) / 2;
			trial = 256'(2 * q - 1) * 256'(2 * q - 1) * 256'(den);
			if (trial <= target) lo = q;
			else hi = q - 1;
		end
		if (num < 0) return sat_q(-lo);
		return sat_q(lo);
	endfunction

	function automatic basis_t camera_basis(longint ox, longint oy, longint oz);
		basis_t b;
		longint fx, fy, fz, one;
		longint unsigned s2, dup;
		one = longint'(1) << FRAC_BITS;
		b = '0;
		if (ox == 0 && oz == 0 && (oy == one || oy == -one)) begin
			b.rx = sat_q(one);
			b.uz = (oy == one) ? sat_q(one) : sat_q(-one);
			b.fy = (oy == one) ? sat_q(-one) : sat_q(one);
		end else if (ox == 0 && oz == 0) begin
			b.degen = 1'b1;
		end else begin
			fx = sat_q(-ox);
			fy = sat_q(-oy);
			fz = sat_q(-oz);
			s2 = fx * fx + fz * fz;
			dup = s2 * (longint'(fy * fy) + s2);
			b.rx = root_quot(fz * one, s2);
			b.rz = root_quot(-fx * one, s2);
			b.ux = root_quot(-(fx * fy) * one, dup);
			b.uy = root_quot(longint'(s2) * one, dup);
			b.uz = root_quot(-(fy * fz) * one, dup);
			b.fx = 16'(fx);
			b.fy = 16'(fy);
			b.fz = 16'(fz);
		end
		return b;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	assign pending = basis_queue.size();
	assign fail_count = fails;

	// predict on orientation transactions, compare on basis transactions
	always @(posedge clk) begin
		basis_t e;
		if (arst_n) begin
			if (orient.valid && orient.ready)
				basis_queue.push_back(camera_basis(orient.orient_x, orient.orient_y,
					orient.orient_z));
			if (basis.valid && basis.ready) begin
				if (basis_queue.size() == 0) begin
					report_mismatch("unexpected transaction", 1, 0);
				end else begin
					e = basis_queue.pop_front();
					if (basis.right_x !== e.rx) report_mismatch("right_x", basis.right_x, e.rx);
					if (basis.right_y !== e.ry) report_mismatch("right_y", basis.right_y, e.ry);
					if (basis.right_z !== e.rz) report_mismatch("right_z", basis.right_z, e.rz);
					if (basis.up_x !== e.ux) report_mismatch("up_x", basis.up_x, e.ux);
					if (basis.up_y !== e.uy) report_mismatch("up_y", basis.up_y, e.uy);
					if (basis.up_z !== e.uz) report_mismatch("up_z", basis.up_z, e.uz);
					if (basis.fwd_x !== e.fx) report_mismatch("fwd_x", basis.fwd_x, e.fx);
					if (basis.fwd_y !== e.fy) report_mismatch("fwd_y", basis.fwd_y, e.fy);
					if (basis.fwd_z !== e.fz) report_mismatch("fwd_z", basis.fwd_z, e.fz);
					if (basis.degenerate !== e.degen)
						report_mismatch("degenerate", basis.degenerate, e.degen);
				end
			end
		end
	end
endmodule

/* bench/testbench.sv */
// testbench top: orientation stimulus, result back-pressure and verdict
`timescale 1ns / 1ps
module testbench;
	import clb_pkg::*;

	localparam int N_RANDOM = 1700;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending, cycles = 0;
	logic quiet = 1'b0;
	logic signed [15:0] dir_x[$], dir_y[$], dir_z[$];

	clb_orient_if orient();
	clb_basis_if basis();

	camera_look_at_basis dut(.clk(clk), .arst_n(arst_n), .orient(orient), .basis(basis));
	clb_checker u_checker(.clk(clk), .arst_n(arst_n), .orient(orient), .basis(basis),
		.fail_count(fail_count), .pending(pending));

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** camera_look_at_basis: FAILED **");
			$finish;
		end
	end

	// receiver stalls in random bursts
	initial begin
		int n;
		basis.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				basis.ready <= 1'b0;
				n = $urandom_range(1, 3);
				repeat (n - 1) @(posedge clk);
			end else begin
				basis.ready <= 1'b1;
			end
		end
	end

	task automatic add_dir(int x, int y, int z);
		dir_x.push_back(16'(x));
		dir_y.push_back(16'(y));
		dir_z.push_back(16'(z));
	endtask

	// one orientation transaction, with an optional idle burst before it
	task automatic send_orient(logic signed [15:0] x, logic signed [15:0] y,
		logic signed [15:0] z);
		int n;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			orient.valid <= 1'b0;
			n = $urandom_range(1, 3);
			repeat (n) @(posedge clk);
		end
		orient.valid <= 1'b1;
		orient.orient_x <= x;
		orient.orient_y <= y;
		orient.orient_z <= z;
		do @(posedge clk); while (!orient.ready);
	endtask

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 4) - 2);
			1: return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
			2: return 16'($urandom_range(0, 2 * ONE) - ONE);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int wait_cycles;
		logic signed [15:0] x, y, z;
		orient.valid = 1'b0;
		orient.orient_x = '0;
		orient.orient_y = '0;
		orient.orient_z = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// straight up/down, degenerate, saturation and extremes
		add_dir(0, ONE, 0);
		add_dir(0, -ONE, 0);
		add_dir(0, 0, 0);
		add_dir(0, 32767, 0);
		add_dir(0, -32768, 0);
		add_dir(0, ONE + 1, 0);
		add_dir(-32768, 0, 0);
		add_dir(0, 0, -32768);
		add_dir(-32768, -32768, -32768);
		add_dir(32767, 32767, 32767);
		add_dir(32767, -32768, -32768);
		add_dir(1, 0, 0);
		add_dir(0, 0, 1);
		add_dir(-1, 32767, 0);
		add_dir(1, -32768, -1);
		add_dir(ONE, 0, 0);
		add_dir(0, 5, -ONE);
		add_dir(-ONE, ONE, ONE);
		add_dir(1, 32767, 1);
		add_dir(-32768, 1, 32767);
		foreach (dir_x[i]) send_orient(dir_x[i], dir_y[i], dir_z[i]);

		for (int i = 0; i < N_RANDOM; i++) begin
			// hold off once until the pipeline drains
			if (i == N_RANDOM / 2) begin
				orient.valid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
			if (i == N_RANDOM - 200) quiet <= 1'b1;
			x = rand_comp();
			y = rand_comp();
			z = rand_comp();
			if ($urandom_range(0, 15) == 0) begin
				x = 0;
				z = 0;
			end
			send_orient(x, y, z);
		end
		orient.valid <= 1'b0;

		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (30) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** camera_look_at_basis: PASSED **");
		else
			$display("** camera_look_at_basis: FAILED **");
		$finish;
	end
endmodule
